// ===== rtl/core/indexed_insert_remove_array_macros.svh =====
// Assertion macros for the indexed insert/remove array.
// Uses the clk_i and rst_ni names of the module that includes it.
`ifndef INDEXED_INSERT_REMOVE_ARRAY_MACROS_SVH
`define INDEXED_INSERT_REMOVE_ARRAY_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define IIAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define IIAR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define IIAR_ASSERT(lbl, prop, msg)
`define IIAR_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/iiar_pkg.sv =====
// Shared types and constants of the indexed insert/remove array.
// Used by iiar_cell and indexed_insert_remove_array; depends on nothing.
package iiar_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    cmd_e              cmd;
    logic              ok;
    logic [CntW-1:0]   pos;
    logic [CntW-1:0]   count;
    logic [DataW-1:0]  value;
  } cell_ctl_t;

endpackage

// ===== rtl/core/indexed_insert_remove_array.sv =====
// Top level of the indexed insert/remove array: command decode, count and result word.
// Depends on iiar_pkg, iiar_cell and indexed_insert_remove_array_macros.svh.
//
// channel  | direction | handshake          | fields
// request  | in        | start_i / busy_o   | cmd_i, position_i, item_value_i
// result   | out       | done_o (one cycle) | read_value_o, entry_count_o, is_empty_o, status_o
//
// Every request is carried out at once: the cell chain shifts all entries in
// parallel at the accepting edge, and done_o pulses in the following cycle.
// busy_o stays low, so a new word can be taken on every edge.
// Reset clears the entry count; cell contents stay unknown until written.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "indexed_insert_remove_array_macros.svh"

module indexed_insert_remove_array (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        cmd_i,
  input  logic [iiar_pkg::CntW-1:0]         position_i,
  input  logic signed [iiar_pkg::DataW-1:0] item_value_i,
  output logic                              done_o,
  output logic signed [iiar_pkg::DataW-1:0] read_value_o,
  output logic [iiar_pkg::CntW-1:0]         entry_count_o,
  output logic                              is_empty_o,
  output logic [1:0]                        status_o
);

  localparam logic [iiar_pkg::CntW-1:0] CapCnt = iiar_pkg::CntW'(iiar_pkg::Capacity);

  iiar_pkg::cmd_e             cmd;
  iiar_pkg::status_e          status_d;
  iiar_pkg::cell_ctl_t        ctl;
  logic                       accept;
  logic                       full;
  logic [iiar_pkg::CntW-1:0]  count_q, count_d;
  logic [iiar_pkg::DataW-1:0] data_w [iiar_pkg::Capacity];
  logic [iiar_pkg::DataW-1:0] rd_w   [iiar_pkg::Capacity];
  logic [iiar_pkg::DataW-1:0] rd_or;

  logic                       done_q;
  logic [iiar_pkg::DataW-1:0] read_value_q;
  logic [iiar_pkg::CntW-1:0]  entry_count_q;
  logic                       is_empty_q;
  iiar_pkg::status_e          status_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign cmd    = iiar_pkg::cmd_e'(cmd_i);
  assign full   = (count_q >= CapCnt);

  // Decode status and the next count
  always_comb begin
    status_d = iiar_pkg::ST_OK;
    count_d  = count_q;
    case (cmd)
      iiar_pkg::CMD_APPEND: begin
        if (full) status_d = iiar_pkg::ST_FULL;
        else count_d = count_q + iiar_pkg::CntW'(1);
      end
      iiar_pkg::CMD_INSERT: begin
        if (position_i > count_q) status_d = iiar_pkg::ST_RANGE;
        else if (full) status_d = iiar_pkg::ST_FULL;
        else count_d = count_q + iiar_pkg::CntW'(1);
      end
      iiar_pkg::CMD_READ: begin
        if (position_i >= count_q) status_d = iiar_pkg::ST_RANGE;
      end
      iiar_pkg::CMD_REMOVE: begin
        if (position_i >= count_q) status_d = iiar_pkg::ST_RANGE;
        else count_d = count_q - iiar_pkg::CntW'(1);
      end
      default: status_d = iiar_pkg::ST_OK;
    endcase
  end

  // Broadcast the command to the chain
  assign ctl.cmd   = cmd;
  assign ctl.ok    = accept && (status_d == iiar_pkg::ST_OK);
  assign ctl.pos   = position_i;
  assign ctl.count = count_q;
  assign ctl.value = item_value_i;

  // Build the cell chain; the first cell takes the item value from the left, the last sees its own word
  for (genvar g = 0; g < iiar_pkg::Capacity; g++) begin : g_cell
    logic [iiar_pkg::DataW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = item_value_i;
    end else begin : g_mid_l
      assign left_w = data_w[g-1];
    end
    if (g == iiar_pkg::Capacity - 1) begin : g_last
      assign right_w = data_w[g];
    end else begin : g_mid_r
      assign right_w = data_w[g+1];
    end
    iiar_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (iiar_pkg::IdxW'(g)),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data_w[g]),
      .rd_o    (rd_w[g])
    );
  end

  // Merge the one addressed cell onto the read bus
  always_comb begin
    rd_or = '0;
    for (int k = 0; k < iiar_pkg::Capacity; k++) begin
      rd_or = rd_or | rd_w[k];
    end
  end

  // Hold count and control, register the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q  <= (cmd == iiar_pkg::CMD_READ && status_d == iiar_pkg::ST_OK) ?
                       rd_or : '0;
      entry_count_q <= count_d;
      is_empty_q    <= (count_d == '0);
      status_q      <= status_d;
    end
  end

  assign done_o        = done_q;
  assign read_value_o  = read_value_q;
  assign entry_count_o = entry_count_q;
  assign is_empty_o    = is_empty_q;
  assign status_o      = status_q;

  `IIAR_ASSERT(a_count_cap, count_q <= CapCnt, "entry count above capacity")
  `IIAR_ASSERT(a_done_follows, accept |=> done_o, "accepted request gave no result")
  `IIAR_ASSERT_IMPLY(a_full_count, done_o && status_o == iiar_pkg::ST_FULL,
                     entry_count_o == CapCnt, "full status with spare room")
  `IIAR_ASSERT_IMPLY(a_empty_flag, done_o, is_empty_o == (entry_count_o == '0),
                     "empty flag disagrees with count")
  `IIAR_ASSERT_IMPLY(a_count_match, done_o, entry_count_o == count_q,
                     "reported count differs from held count")

endmodule

// ===== rtl/core/iiar_cell.sv =====
// One storage cell of the list chain: holds one entry and shifts with its neighbors.
// Depends on iiar_pkg.
module iiar_cell (
  input  logic                       clk_i,
  input  iiar_pkg::cell_ctl_t        ctl_i,
  input  logic [iiar_pkg::IdxW-1:0]  idx_i,
  input  logic [iiar_pkg::DataW-1:0] left_i,
  input  logic [iiar_pkg::DataW-1:0] right_i,
  output logic [iiar_pkg::DataW-1:0] data_o,
  output logic [iiar_pkg::DataW-1:0] rd_o
);

  logic [iiar_pkg::DataW-1:0] data_q, data_d;
  logic [iiar_pkg::CntW-1:0]  me;

  assign me = iiar_pkg::CntW'(idx_i);

  // Pick the next word: load, take from below, take from above, or hold
  always_comb begin
    data_d = data_q;
    if (ctl_i.ok) begin
      case (ctl_i.cmd)
        iiar_pkg::CMD_APPEND: begin
          if (me == ctl_i.count) data_d = ctl_i.value;
        end
        iiar_pkg::CMD_INSERT: begin
          if (me == ctl_i.pos) data_d = ctl_i.value;
          else if (me > ctl_i.pos) data_d = left_i;
        end
        iiar_pkg::CMD_REMOVE: begin
          if (me >= ctl_i.pos) data_d = right_i;
        end
        default: data_d = data_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Drive the read bus only when addressed
  assign data_o = data_q;
  assign rd_o   = (me == ctl_i.pos) ? data_q : '0;

endmodule
